// ===== rtl/prq_pkg.sv =====
// shared types, codes and defaults for the receive packet queue
`default_nettype none

package prq_pkg;

    // defaults for the top level parameters
    localparam int DEF_QUEUE_ENTRIES = 16;
    localparam int DEF_PAYLOAD_BYTES = 512;

    // command codes
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DROP  = 2'd2,
        ST_EVICT = 2'd3
    } t_status;

    // one command beat
    typedef struct packed {
        t_op         op;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] read_limit;
    } t_cmd_beat;

    // one result beat
    typedef struct packed {
        t_status     status;
        logic [31:0] src_ip_res;
        logic [15:0] src_port_res;
        logic [15:0] dst_port_res;
        logic [63:0] data_word;
        logic [3:0]  word_bytes;
        logic        last;
        logic [4:0]  entries;
    } t_res_beat;

    // payload byte write toward the payload store
    typedef struct packed {
        logic       en;
        logic [2:0] lane;
        logic [7:0] data;
    } t_pay_wr;

endpackage

`default_nettype wire

// ===== rtl/packet_rx_queue_drop_oldest.sv =====
// receive queue of datagrams with drop-oldest overflow, top level
//
// Command channel: an item on i_item is taken when start is high and busy is
// low. Push items carry one payload byte each; the header fields are taken
// on the first byte of a packet and last_byte closes it. Results appear on
// o_result for one cycle, flagged by o_done; the receiver cannot stall, so
// every result beat is taken as it is shown.
// Sequence, from the accepting edge to the edge that takes the result: a push
// byte that is not the last gives no result, so bytes stream at one per
// cycle. Clear, and pop or peek on an empty queue, answer in the next cycle.
// A closing byte passes through S_PUSH_FIN, busy while the slot order
// memory is read for the new spare slot, then answers. Peek on a non-empty
// queue reads slot order, then header memory (S_RD_SLOT, S_RD_HDR), then
// answers. Pop does the same, then streams one 8-byte payload beat per cycle
// in S_DATA; a zero-length pop answers straight after S_RD_HDR.
// Reset empties the queue and the packet under assembly; payload and header
// memories are not cleared, and positions of the slot order never written
// read as their own index (tracked by a fill mark), so no clearing pass.
`default_nettype none

module packet_rx_queue_drop_oldest
    import prq_pkg::*;
#(
    parameter int QUEUE_ENTRIES = DEF_QUEUE_ENTRIES,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_cmd_beat i_item,
    output logic           busy,
    output logic           o_done,
    output t_res_beat      o_result
);

    localparam int SLOT_COUNT = QUEUE_ENTRIES + 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int POS_W      = $clog2(QUEUE_ENTRIES);
    localparam int CNT_W      = $clog2(QUEUE_ENTRIES + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int LEN_W      = $clog2(PAYLOAD_BYTES + 1);
    localparam int WPS        = (PAYLOAD_BYTES + 7) / 8;
    localparam int WIDX_W     = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int HDR_W      = 64 + LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_FIN,
        S_RD_SLOT,
        S_RD_HDR,
        S_DATA
    } t_state;

    // control state
    t_state             r_state,    n_state;
    logic [POS_W-1:0]   r_head,     n_head;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [SLOT_W-1:0]  r_spare,    n_spare;
    logic [CNT_W-1:0]   r_fill,     n_fill;
    logic [LEN_W-1:0]   r_asm_len,  n_asm_len;
    logic               r_asm_ovf,  n_asm_ovf;
    logic               r_done,     n_done;
    t_res_beat          r_res,      n_res;

    // payload of the current command
    logic [31:0]        r_asm_ip,    n_asm_ip;
    logic [15:0]        r_asm_sport, n_asm_sport;
    logic [15:0]        r_asm_dport, n_asm_dport;
    logic               r_is_pop,    n_is_pop;
    logic [15:0]        r_limit,     n_limit;
    logic               r_drop,      n_drop;
    t_status            r_pstat,     n_pstat;
    logic [SLOT_W-1:0]  r_slot,      n_slot;
    logic [31:0]        r_pip,       n_pip;
    logic [15:0]        r_psport,    n_psport;
    logic [15:0]        r_pdport,    n_pdport;
    logic [LEN_W-1:0]   r_remain,    n_remain;
    logic [WIDX_W-1:0]  r_widx,      n_widx;

    // memories and their read registers
    logic [SLOT_W-1:0]  so_mem  [QUEUE_ENTRIES];
    logic [HDR_W-1:0]   hdr_mem [SLOT_COUNT];
    logic [SLOT_W-1:0]  r_so_q;
    logic               r_so_hit;
    logic [POS_W-1:0]   r_so_idx;
    logic [HDR_W-1:0]   r_hdr_q;

    // memory controls
    logic               so_we;
    logic [POS_W-1:0]   so_waddr;
    logic [POS_W-1:0]   so_raddr;
    logic               hdr_we;
    logic [HDR_W-1:0]   hdr_wdata;
    t_pay_wr            pay_wr;
    logic               prd_en;
    logic [WIDX_W-1:0]  prd_widx;
    logic [63:0]        prd_data;

    // combinational helpers
    logic               w_accept;
    logic               w_first;
    logic               w_room;
    logic [LEN_W-1:0]   w_len_new;
    logic               w_ovf_new;
    logic               w_full;
    logic [SUM_W-1:0]   w_sum;
    logic [POS_W-1:0]   w_tail;
    logic [POS_W-1:0]   w_head_inc;
    logic [POS_W-1:0]   w_pos;
    logic [SLOT_W-1:0]  w_so_val;
    logic [LEN_W-1:0]   w_hdr_len;
    logic [LEN_W-1:0]   w_n;
    logic [3:0]         w_nb;
    logic [63:0]        w_word;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    // assembly bookkeeping
    assign w_first   = (r_asm_len == '0) && !r_asm_ovf;
    assign w_room    = (r_asm_len < LEN_W'(PAYLOAD_BYTES));
    assign w_len_new = w_room ? (r_asm_len + LEN_W'(1)) : r_asm_len;
    assign w_ovf_new = r_asm_ovf || !w_room;

    // queue position arithmetic
    assign w_full     = (r_count >= CNT_W'(QUEUE_ENTRIES));
    assign w_sum      = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail     = (w_sum >= SUM_W'(QUEUE_ENTRIES))
                        ? POS_W'(w_sum - SUM_W'(QUEUE_ENTRIES)) : POS_W'(w_sum);
    assign w_head_inc = (r_head == POS_W'(QUEUE_ENTRIES - 1))
                        ? '0 : (r_head + POS_W'(1));
    assign w_pos      = w_full ? r_head : w_tail;

    // slot order read: unwritten positions hold their own index
    assign w_so_val = r_so_hit ? r_so_q : SLOT_W'(r_so_idx);

    // pop delivery length and current beat size
    assign w_hdr_len = r_hdr_q[LEN_W-1:0];
    assign w_n       = (16'(w_hdr_len) < r_limit) ? w_hdr_len : LEN_W'(r_limit);
    assign w_nb      = (r_remain > LEN_W'(8)) ? 4'd8 : 4'(r_remain);

    // mask payload bytes beyond the valid count
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_word[b*8 +: 8] = (4'(b) < w_nb) ? prd_data[b*8 +: 8] : 8'h00;
        end
    end

    // header write value for a completed packet
    assign hdr_wdata = {(w_first ? i_item.src_ip   : r_asm_ip),
                        (w_first ? i_item.src_port : r_asm_sport),
                        (w_first ? i_item.dst_port : r_asm_dport),
                        w_len_new};

    // next state
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_spare     = r_spare;
        n_fill      = r_fill;
        n_asm_len   = r_asm_len;
        n_asm_ovf   = r_asm_ovf;
        n_asm_ip    = r_asm_ip;
        n_asm_sport = r_asm_sport;
        n_asm_dport = r_asm_dport;
        n_is_pop    = r_is_pop;
        n_limit     = r_limit;
        n_drop      = r_drop;
        n_pstat     = r_pstat;
        n_slot      = r_slot;
        n_pip       = r_pip;
        n_psport    = r_psport;
        n_pdport    = r_pdport;
        n_remain    = r_remain;
        n_widx      = r_widx;
        n_done      = 1'b0;
        n_res       = '0;
        so_we       = 1'b0;
        so_waddr    = w_pos;
        so_raddr    = r_head;
        hdr_we      = 1'b0;
        pay_wr.en   = 1'b0;
        pay_wr.lane = r_asm_len[2:0];
        pay_wr.data = i_item.data_byte;
        prd_en      = 1'b0;
        prd_widx    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.op)
                        OP_PUSH: begin
                            pay_wr.en = w_room;
                            if (w_first) begin
                                n_asm_ip    = i_item.src_ip;
                                n_asm_sport = i_item.src_port;
                                n_asm_dport = i_item.dst_port;
                            end
                            if (!i_item.last_byte) begin
                                n_asm_len = w_len_new;
                                n_asm_ovf = w_ovf_new;
                            end else begin
                                n_asm_len = '0;
                                n_asm_ovf = 1'b0;
                                n_drop    = w_ovf_new;
                                n_state   = S_PUSH_FIN;
                                if (w_ovf_new) begin
                                    n_pstat = ST_DROP;
                                end else begin
                                    hdr_we   = 1'b1;
                                    so_we    = 1'b1;
                                    so_raddr = w_pos;
                                    if (CNT_W'(w_pos) == r_fill) begin
                                        n_fill = r_fill + CNT_W'(1);
                                    end
                                    if (w_full) begin
                                        n_head  = w_head_inc;
                                        n_pstat = ST_EVICT;
                                    end else begin
                                        n_count = r_count + CNT_W'(1);
                                        n_pstat = ST_OK;
                                    end
                                end
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_done         = 1'b1;
                                n_res.status   = ST_EMPTY;
                                n_res.last     = 1'b1;
                            end else begin
                                n_is_pop = (i_item.op == OP_POP);
                                n_limit  = i_item.read_limit;
                                n_state  = S_RD_SLOT;
                            end
                        end
                        OP_CLEAR: begin
                            n_head       = '0;
                            n_count      = '0;
                            n_done       = 1'b1;
                            n_res.status = ST_OK;
                            n_res.last   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // new spare slot comes back from slot order memory
            S_PUSH_FIN: begin
                if (!r_drop) begin
                    n_spare = w_so_val;
                end
                n_done        = 1'b1;
                n_res.status  = r_pstat;
                n_res.last    = 1'b1;
                n_res.entries = 5'(r_count);
                n_state       = S_IDLE;
            end
            // head slot known, header read under way
            S_RD_SLOT: begin
                n_slot  = w_so_val;
                n_state = S_RD_HDR;
            end
            S_RD_HDR: begin
                if (!r_is_pop) begin
                    n_done             = 1'b1;
                    n_res.status       = ST_OK;
                    n_res.dst_port_res = r_hdr_q[LEN_W+15 -: 16];
                    n_res.last         = 1'b1;
                    n_res.entries      = 5'(r_count);
                    n_state            = S_IDLE;
                end else begin
                    n_head   = w_head_inc;
                    n_count  = r_count - CNT_W'(1);
                    n_pip    = r_hdr_q[HDR_W-1 -: 32];
                    n_psport = r_hdr_q[LEN_W+31 -: 16];
                    n_pdport = r_hdr_q[LEN_W+15 -: 16];
                    if (w_n == '0) begin
                        n_done             = 1'b1;
                        n_res.status       = ST_OK;
                        n_res.src_ip_res   = r_hdr_q[HDR_W-1 -: 32];
                        n_res.src_port_res = r_hdr_q[LEN_W+31 -: 16];
                        n_res.dst_port_res = r_hdr_q[LEN_W+15 -: 16];
                        n_res.last         = 1'b1;
                        n_res.entries      = 5'(r_count - CNT_W'(1));
                        n_state            = S_IDLE;
                    end else begin
                        prd_en   = 1'b1;
                        prd_widx = '0;
                        n_remain = w_n;
                        n_widx   = WIDX_W'(1);
                        n_state  = S_DATA;
                    end
                end
            end
            // one payload beat per cycle
            S_DATA: begin
                n_done             = 1'b1;
                n_res.status       = ST_OK;
                n_res.src_ip_res   = r_pip;
                n_res.src_port_res = r_psport;
                n_res.dst_port_res = r_pdport;
                n_res.data_word    = w_word;
                n_res.word_bytes   = w_nb;
                n_res.entries      = 5'(r_count);
                if (r_remain <= LEN_W'(8)) begin
                    n_res.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    prd_en   = 1'b1;
                    prd_widx = r_widx;
                    n_remain = r_remain - LEN_W'(8);
                    n_widx   = r_widx + WIDX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_spare   <= SLOT_W'(QUEUE_ENTRIES);
            r_fill    <= '0;
            r_asm_len <= '0;
            r_asm_ovf <= 1'b0;
            r_done    <= 1'b0;
            r_res     <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_spare   <= n_spare;
            r_fill    <= n_fill;
            r_asm_len <= n_asm_len;
            r_asm_ovf <= n_asm_ovf;
            r_done    <= n_done;
            r_res     <= n_res;
        end
        r_asm_ip    <= n_asm_ip;
        r_asm_sport <= n_asm_sport;
        r_asm_dport <= n_asm_dport;
        r_is_pop    <= n_is_pop;
        r_limit     <= n_limit;
        r_drop      <= n_drop;
        r_pstat     <= n_pstat;
        r_slot      <= n_slot;
        r_pip       <= n_pip;
        r_psport    <= n_psport;
        r_pdport    <= n_pdport;
        r_remain    <= n_remain;
        r_widx      <= n_widx;
    end

    // slot order memory, read before write on the same position
    always_ff @(posedge i_clk) begin
        if (so_we) begin
            so_mem[so_waddr] <= r_spare;
        end
        r_so_q   <= so_mem[so_raddr];
        r_so_hit <= (CNT_W'(so_raddr) < r_fill);
        r_so_idx <= so_raddr;
    end

    // header memory
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            hdr_mem[r_spare] <= hdr_wdata;
        end
        r_hdr_q <= hdr_mem[w_so_val];
    end

    // payload memory
    prq_payload_store #(
        .SLOT_W (SLOT_W),
        .WIDX_W (WIDX_W)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr      (pay_wr),
        .i_wr_slot (r_spare),
        .i_wr_widx (WIDX_W'(r_asm_len >> 3)),
        .i_rd_en   (prd_en),
        .i_rd_slot (r_slot),
        .i_rd_widx (prd_widx),
        .o_rd_data (prd_data)
    );

    // occupancy and slot bookkeeping stay in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(QUEUE_ENTRIES)) && (r_fill <= CNT_W'(QUEUE_ENTRIES)))
        else $error("queue count or fill mark out of range");

    a_spare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare < SLOT_W'(SLOT_COUNT))
        else $error("spare slot out of range");

    // clear answers in the next cycle with an empty queue
    a_clear_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.op == OP_CLEAR))
        |=> (o_done && o_result.last && (o_result.entries == '0)))
        else $error("clear did not answer with an empty queue");

    // a closing push byte is first busy with no result, then gives its status beat
    a_push_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.op == OP_PUSH) && i_item.last_byte)
        |=> (busy && !o_done) ##1 (o_done && o_result.last))
        else $error("closing push byte without its status beat");

endmodule

`default_nettype wire

// ===== rtl/prq_payload_store.sv =====
// payload word memory with byte-lane assembly of the incoming packet
`default_nettype none

module prq_payload_store
    import prq_pkg::*;
#(
    parameter int SLOT_W = 5,
    parameter int WIDX_W = 6
) (
    input  wire logic                i_clk,
    input  wire t_pay_wr             i_wr,
    input  wire logic [SLOT_W-1:0]   i_wr_slot,
    input  wire logic [WIDX_W-1:0]   i_wr_widx,
    input  wire logic                i_rd_en,
    input  wire logic [SLOT_W-1:0]   i_rd_slot,
    input  wire logic [WIDX_W-1:0]   i_rd_widx,
    output logic [63:0]              o_rd_data
);

    localparam int DEPTH = (1 << (SLOT_W + WIDX_W));

    logic [63:0] mem [DEPTH];
    logic [63:0] r_word;
    logic [63:0] n_word;

    // merge the new byte into the word being assembled
    always_comb begin
        n_word = r_word;
        n_word[i_wr.lane*8 +: 8] = i_wr.data;
    end

    // assembly word, written through to memory on every byte
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_word <= n_word;
            mem[{i_wr_slot, i_wr_widx}] <= n_word;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[{i_rd_slot, i_rd_widx}];
        end
    end

endmodule

`default_nettype wire
